FILE: rtl/bcss_pkg.sv
package bcss_pkg;

    // Sizes of the block.
    localparam int TEXT_MAX_DEFAULT    = 64;
    localparam int PATTERN_MAX_DEFAULT = 8;
    localparam int ALPHABET_SIZE       = 256;
    localparam int RESULT_CAP          = 64;

    // Field and register widths.
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int PAT_BYTES  = 8;
    localparam int PAT_W      = PAT_BYTES * BYTE_W;
    localparam int PLEN_W     = 4;
    localparam int PCUR_W     = 3;
    localparam int SKIP_W     = 4;
    localparam int CFG_DATA_W = PAT_W;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    // One result item.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             overflow;
        logic             last_result;
    } result_t;

    // Bad-character skip value of one text byte: the distance from the last
    // occurrence of the byte in the pattern to the pattern end, or the
    // pattern length when the byte does not occur in it.
    function automatic logic [SKIP_W-1:0] skip_value(
        input logic [PAT_W-1:0]  pattern,
        input logic [PLEN_W-1:0] len,
        input logic [BYTE_W-1:0] c
    );
        logic [SKIP_W-1:0] skip;
        skip = SKIP_W'(len);
        for (int i = 0; i < PAT_BYTES; i++) begin
            if ((PLEN_W'(i) < len) && (pattern[i*BYTE_W +: BYTE_W] == c)) begin
                skip = SKIP_W'(len - PLEN_W'(i) - PLEN_W'(1));
            end
        end
        return skip;
    endfunction

endpackage

FILE: rtl/bcss_if.sv
// Text channel: one byte per transfer.
interface bcss_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// Result channel: one match report per transfer.
interface bcss_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] match_position;
    logic       overflow;
    logic       last_result;

    modport source (output valid, output found, output match_position,
                    output overflow, output last_result, input ready);
    modport sink   (input valid, input found, input match_position,
                    input overflow, input last_result, output ready);
endinterface

FILE: rtl/bad_character_string_search.sv
// Boyer-Moore bad-character string search.
// Text bytes arrive on text_in, one per transfer, and are taken one per cycle
// while the block is idle. The byte with final_byte set ends the text and
// starts the search; up to TEXT_MAX bytes are kept, later ones are dropped
// and every result of that search then carries overflow.
// The search compares one text byte against one pattern byte per step; each
// step passes through a read state and a compare state because the text
// buffer has a registered read port. text_in is not ready during the search
// and accepts the next text right after it.
// Results leave on result_out in text order, one per match, non-overlapping;
// the last one carries last_result. Without a match a single result with
// found low and last_result high is given. A match is held back until the
// next one is found or the search ends, so its last_result flag is known.
// When the receiver stalls, the search halts at the next match until the
// output register is free. Reset empties the text buffer and sets
// pattern_bytes to 0 and pattern_length to 1. Configuration is to be written
// only while the block is idle; the block itself does not enforce it.
module bad_character_string_search
#(
    parameter int TEXT_MAX    = bcss_pkg::TEXT_MAX_DEFAULT,
    parameter int PATTERN_MAX = bcss_pkg::PATTERN_MAX_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    bcss_text_if.sink                     text_in,
    bcss_result_if.source                 result_out,
    input  logic                          write_enable,
    input  logic [bcss_pkg::CFG_IDX_W-1:0]  register_index,
    input  logic [bcss_pkg::CFG_DATA_W-1:0] write_data
);
    import bcss_pkg::*;

    localparam int AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
    localparam int CW = $clog2(TEXT_MAX + 1);
    localparam int TW = $clog2(TEXT_MAX + PAT_BYTES + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int MW = $clog2(RESULT_CAP + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_WINDOW = 6'b000010,
        ST_READ   = 6'b000100,
        ST_CMP    = 6'b001000,
        ST_MATCH  = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [PAT_W-1:0]   pattern_reg;
    logic [PLEN_W-1:0]  plen_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      base_reg, base_next;
    logic [TW-1:0]      tc_reg, tc_next;
    logic [PCUR_W-1:0]  pc_reg, pc_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]   pend_pos_reg, pend_pos_next;
    logic [MW-1:0]      matches_reg, matches_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;
    logic [BYTE_W-1:0]  rdata_reg;
    logic [BYTE_W-1:0]  text_mem [TEXT_MAX];

    logic               accept;
    logic               mem_we;
    logic [AW-1:0]      rd_addr;
    logic [PLEN_W-1:0]  m;
    logic [CW-1:0]      len;
    logic               out_free;
    logic [BYTE_W-1:0]  pat_byte;
    logic               hit;
    logic [SKIP_W-1:0]  skip;
    logic [SKIP_W-1:0]  miss_dist;
    logic [SKIP_W-1:0]  shift;
    logic [TW-1:0]      tc_shifted;
    logic [PW-1:0]      pos_wide;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pattern_reg <= '0;
            plen_reg    <= PLEN_W'(1);
        end else if (write_enable) begin
            unique case (cfg_reg_t'(register_index))
                REG_PATTERN_BYTES:  pattern_reg <= write_data;
                REG_PATTERN_LENGTH: plen_reg    <= write_data[PLEN_W-1:0];
            endcase
        end
    end

    // Effective pattern length, clamped to 1..PATTERN_MAX.
    always_comb begin
        if (plen_reg == '0) begin
            m = PLEN_W'(1);
        end else if (plen_reg > PLEN_W'(PATTERN_MAX)) begin
            m = PLEN_W'(PATTERN_MAX);
        end else begin
            m = plen_reg;
        end
    end

    // Text buffer with a registered read port.
    assign rd_addr = AW'(TW'(base_reg) + tc_reg);

    always_ff @(posedge clk) begin
        if (mem_we) begin
            text_mem[count_reg[AW-1:0]] <= text_in.text_byte;
        end
        rdata_reg <= text_mem[rd_addr];
    end

    // Shared compare and shift unit.
    assign len        = count_reg - base_reg;
    assign pat_byte   = pattern_reg[{pc_reg, 3'b000} +: BYTE_W];
    assign hit        = (rdata_reg == pat_byte);
    assign skip       = skip_value(pattern_reg, m, rdata_reg);
    assign miss_dist  = SKIP_W'(m - PLEN_W'(pc_reg));
    assign shift      = (miss_dist > skip) ? miss_dist : skip;
    assign tc_shifted = tc_reg + TW'(shift);
    assign pos_wide   = PW'(base_reg) + PW'(tc_reg);

    assign accept          = text_in.valid && text_in.ready;
    assign text_in.ready   = (state_reg == ST_IDLE);
    assign out_free        = !res_valid_reg || result_out.ready;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        base_next       = base_reg;
        tc_next         = tc_reg;
        pc_next         = pc_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        matches_next    = matches_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;

        // The output register empties on a transfer.
        if (res_valid_reg && result_out.ready) begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (count_reg < CW'(TEXT_MAX)) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (text_in.final_byte) begin
                        base_next       = '0;
                        matches_next    = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_WINDOW;
                    end
                end
            end
            ST_WINDOW:
            begin
                // Too little text left for another occurrence ends the search.
                if (len < CW'(m)) begin
                    state_next = ST_FLUSH;
                end else begin
                    tc_next    = TW'(m - PLEN_W'(1));
                    pc_next    = PCUR_W'(m - PLEN_W'(1));
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (hit && (pc_reg == '0)) begin
                    pos_next   = CW'(pos_wide);
                    state_next = ST_MATCH;
                end else if (hit) begin
                    tc_next    = tc_reg - TW'(1);
                    pc_next    = pc_reg - PCUR_W'(1);
                    state_next = ST_READ;
                end else if (tc_shifted >= TW'(len)) begin
                    state_next = ST_FLUSH;
                end else begin
                    tc_next    = tc_shifted;
                    pc_next    = PCUR_W'(m - PLEN_W'(1));
                    state_next = ST_READ;
                end
            end
            ST_MATCH:
            begin
                // Release the held match, then hold the new one.
                if (out_free) begin
                    if (pend_valid_reg) begin
                        res_valid_next = 1'b1;
                        res_next       = '{found: 1'b1, match_position: pend_pos_reg,
                                           overflow: ovf_reg, last_result: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_pos_next   = POS_W'(PW'(pos_reg));
                    matches_next    = matches_reg + MW'(1);
                    base_next       = pos_reg + CW'(m);
                    if (matches_reg == MW'(RESULT_CAP - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_WINDOW;
                    end
                end
            end
            ST_FLUSH:
            begin
                // Final result of the search, then clear the buffer.
                if (out_free) begin
                    res_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        res_next = '{found: 1'b1, match_position: pend_pos_reg,
                                     overflow: ovf_reg, last_result: 1'b1};
                    end else begin
                        res_next = '{found: 1'b0, match_position: '0,
                                     overflow: ovf_reg, last_result: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    base_next       = '0;
                    tc_next         = '0;
                    pc_next         = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            base_reg       <= '0;
            tc_reg         <= '0;
            pc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            matches_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            base_reg       <= base_next;
            tc_reg         <= tc_next;
            pc_reg         <= pc_next;
            pend_valid_reg <= pend_valid_next;
            matches_reg    <= matches_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk) begin
        pos_reg      <= pos_next;
        pend_pos_reg <= pend_pos_next;
        res_reg      <= res_next;
    end

    // Result channel.
    assign result_out.valid          = res_valid_reg;
    assign result_out.found          = res_reg.found;
    assign result_out.match_position = res_reg.match_position;
    assign result_out.overflow       = res_reg.overflow;
    assign result_out.last_result    = res_reg.last_result;

endmodule

FILE: rtl/bcss_checker.sv
module bcss_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_final,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_found,
    input logic [5:0] out_position,
    input logic       out_last
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_found)
            && $stable(out_position) && $stable(out_last))
        else $error("stalled result changed");

    // A report without a match is always the single, last one at offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_last && (out_position == 6'd0))
        else $error("no-match result malformed");

    // A text byte that is not final keeps the block loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_final |=> in_ready)
        else $error("loading stopped after a non-final byte");

    // The final byte starts a search, during which no text is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final |=> !in_ready)
        else $error("text accepted right after the final byte");

endmodule

bind bad_character_string_search bcss_checker u_bcss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (text_in.valid),
    .in_ready     (text_in.ready),
    .in_final     (text_in.final_byte),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_found    (result_out.found),
    .out_position (result_out.match_position),
    .out_last     (result_out.last_result)
);
